[rtl/dqnf_pkg.sv]
// Shared types and constants for the double-ended queue with negative filter.
package dqnf_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int REQ_W     = 3;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE     = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_PUSH_BACK  = 3'd2,
        REQ_READ_FRONT = 3'd3,
        REQ_READ_BACK  = 3'd4,
        REQ_CLEAR      = 3'd5,
        REQ_DROP_NEG   = 3'd6
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_ISSUE,
        S_RD_LOAD,
        S_FL_ISSUE,
        S_FL_CHECK,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    latch_req;
        logic    create;
        logic    push_front;
        logic    push_back;
        logic    clear;
        logic    rd_issue;
        logic    keep;
        logic    step;
        logic    commit;
        logic    load_out;
        logic    out_data;
        logic    out_last;
        status_t out_status;
    } dq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        req_t req;
        logic empty;
        logic full;
        logic walk_last;
        logic walk_done;
        logic rd_neg;
        logic out_free;
    } dq_stat_t;

endpackage

[rtl/dqnf_ctrl.sv]
// Controller state machine sequencing requests, readout and negative removal.
module dqnf_ctrl
    import dqnf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dq_stat_t stat,
    output dq_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.out_status = ST_OK;
        s_ready     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC: begin
                status_next = ST_OK;
                state_next  = S_RESULT;
                if (stat.req inside {REQ_CREATE, REQ_PUSH_FRONT, REQ_PUSH_BACK}) begin
                    if (stat.empty) begin
                        // push into an empty queue acts as create
                        cmd.create = 1'b1;
                    end else if (stat.req == REQ_CREATE) begin
                        status_next = ST_REFUSED;
                    end else if (stat.full) begin
                        status_next = ST_FULL;
                    end else if (stat.req == REQ_PUSH_FRONT) begin
                        cmd.push_front = 1'b1;
                    end else begin
                        cmd.push_back = 1'b1;
                    end
                end else if (stat.req inside {REQ_READ_FRONT, REQ_READ_BACK}) begin
                    if (stat.empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        state_next = S_RD_ISSUE;
                    end
                end else if (stat.req == REQ_CLEAR) begin
                    cmd.clear = 1'b1;
                end else if (stat.req == REQ_DROP_NEG) begin
                    state_next = S_FL_ISSUE;
                end
            end

            S_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_LOAD;
            end

            S_RD_LOAD: begin
                if (stat.out_free) begin
                    cmd.load_out   = 1'b1;
                    cmd.out_data   = 1'b1;
                    cmd.out_last   = stat.walk_last;
                    cmd.out_status = ST_OK;
                    cmd.step       = 1'b1;
                    state_next     = stat.walk_last ? S_IDLE : S_RD_ISSUE;
                end
            end

            S_FL_ISSUE: begin
                if (stat.walk_done) begin
                    cmd.commit = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_FL_CHECK;
                end
            end

            S_FL_CHECK: begin
                // pack kept entries behind the front
                cmd.keep   = !stat.rd_neg;
                cmd.step   = 1'b1;
                state_next = S_FL_ISSUE;
            end

            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = status_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/dqnf_datapath.sv]
// Datapath: ring storage, pointers, walk counters and output register.
module dqnf_datapath
    import dqnf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [REQ_W-1:0]        s_req_type,
    input  logic signed [VAL_W-1:0] s_value,
    output logic signed [VAL_W-1:0] m_read_value,
    output logic                    m_last,
    output logic [ST_W-1:0]         m_status,
    output logic [CNT_OUT_W-1:0]    m_count,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  dq_cmd_t                 cmd,
    output dq_stat_t                stat
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VAL_W-1:0] mem [DEPTH];

    req_t             req_reg;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] n_reg, n_next;

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_last_reg;
    logic [ST_W-1:0]         out_status_reg;
    logic [CNT_OUT_W-1:0]    out_count_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] pf_pos;
    logic [CNT_W-1:0] rd_off;

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign pf_pos  = ring_pos(front_reg, CNT_W'(DEPTH - 1));
    assign rd_off  = (req_reg == REQ_READ_BACK) ? (count_reg - i_reg - CNT_W'(1)) : i_reg;
    assign rd_addr = ring_pos(front_reg, rd_off);

    always_comb begin
        wr_en   = cmd.create | cmd.push_front | cmd.push_back | cmd.keep;
        wr_data = cmd.keep ? rd_data_reg : value_reg;
        wr_addr = '0;
        if (cmd.push_front) begin
            wr_addr = pf_pos;
        end else if (cmd.push_back) begin
            wr_addr = ring_pos(front_reg, count_reg);
        end else if (cmd.keep) begin
            wr_addr = ring_pos(front_reg, n_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        if (cmd.create || cmd.clear) begin
            front_next = '0;
        end else if (cmd.push_front) begin
            front_next = pf_pos;
        end
        if (cmd.create) begin
            count_next = CNT_W'(1);
        end else if (cmd.push_front || cmd.push_back) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.commit) begin
            count_next = n_reg;
        end
        if (cmd.latch_req) begin
            i_next = '0;
            n_next = '0;
        end else begin
            if (cmd.step) begin
                i_next = i_reg + CNT_W'(1);
            end
            if (cmd.keep) begin
                n_next = n_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            i_reg     <= '0;
            n_reg     <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_reg   <= req_t'(s_req_type);
            value_reg <= s_value;
        end
    end

    // Output register: load a beat, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_value_reg  <= cmd.out_data ? rd_data_reg : '0;
            out_last_reg   <= cmd.out_last;
            out_status_reg <= cmd.out_status;
            out_count_reg  <= CNT_OUT_W'(count_reg);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_value_reg;
    assign m_last       = out_last_reg;
    assign m_status     = out_status_reg;
    assign m_count      = out_count_reg;

    always_comb begin
        stat.req       = req_reg;
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CNT_W'(DEPTH));
        stat.walk_last = ((CNT_W+1)'(i_reg) + (CNT_W+1)'(1)) == (CNT_W+1)'(count_reg);
        stat.walk_done = (i_reg == count_reg);
        stat.rd_neg    = rd_data_reg[VAL_W-1];
        stat.out_free  = !out_valid_reg || m_ready;
    end

endmodule

[rtl/deque_with_negative_filter.sv]
// Double-ended queue of signed words with readout and negative removal.
//
// Requests enter on s_req_type/s_value (s_valid/s_ready) and results leave
// on m_read_value/m_last/m_status/m_count (m_valid/m_ready), one request
// at a time; s_ready is high only while the block is idle.
// Create, push, clear and unknown requests give one beat with last set;
// the beat is loaded in the result state, which follows the execute state,
// and the next request can be taken in the cycle after the beat is loaded.
// A readout gives one beat per held entry, front-to-back or back-to-front,
// each made by one storage read and then one output load, with last on
// the final beat; an empty queue answers one beat with status empty.
// Negative removal walks every held entry, reading each and rewriting the
// kept ones behind the front, then gives one beat with the new count.
// The storage has a single registered read port.
// When the receiver holds m_ready low the current beat is held and a
// readout stops until the output register frees.
// Reset (aresetn low at a clock edge) empties the queue and drops any
// pending beat; storage contents are not cleared.
module deque_with_negative_filter
    import dqnf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [REQ_W-1:0]        s_req_type,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_read_value,
    output logic                    m_last,
    output logic [ST_W-1:0]         m_status,
    output logic [CNT_OUT_W-1:0]    m_count
);

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dqnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dqnf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_req_type   (s_req_type),
        .s_value      (s_value),
        .m_read_value (m_read_value),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

[dv/tb.sv]
// Testbench for the double-ended queue with negative filter: directed table, then random requests.
`timescale 1ns / 1ps

module tb
    import dqnf_pkg::*;
();

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [REQ_W-1:0] REQ_UNDEF = 3'd7;
    localparam int RAND_ITEMS = 310;
    localparam int TAIL_CYCLES = 2 * DEPTH + 20;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type;
    logic signed [VAL_W-1:0] s_value;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [VAL_W-1:0] m_read_value;
    logic                    m_last;
    logic [ST_W-1:0]         m_status;
    logic [CNT_OUT_W-1:0]    m_count;

    typedef struct {
        logic signed [VAL_W-1:0] rd;
        logic                    last;
        status_t                 st;
        logic [CNT_OUT_W-1:0]    cnt;
    } beat_t;

    typedef struct {
        logic [REQ_W-1:0]        rq;
        logic signed [VAL_W-1:0] v;
        int                      rep;
        bit                      typed;
        status_t                 st;
        logic [CNT_OUT_W-1:0]    cnt;
    } step_t;

    // Shadow copy of the queue
    logic signed [VAL_W-1:0] shadow_ring [DEPTH];
    int                      shadow_head;
    int                      shadow_held;

    beat_t expected_beats[$];
    step_t stim_rows[$];

    int err_cnt    = 0;
    int n_req      = 0;
    int n_beats    = 0;
    int n_full     = 0;
    int n_refused  = 0;
    int n_empty_rd = 0;
    int n_filter   = 0;
    int burst_left = 0;

    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_tick  = 0;
    int rx_hold  = 0;

    deque_with_negative_filter #(.DEPTH(DEPTH)) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void push_single(status_t st);
        beat_t b;
        b.rd   = '0;
        b.last = 1'b1;
        b.st   = st;
        b.cnt  = shadow_held[CNT_OUT_W-1:0];
        expected_beats.push_back(b);
    endfunction

    // Advance the shadow queue by one request and queue the beats it gives
    function automatic void model_request(logic [REQ_W-1:0] rq, logic signed [VAL_W-1:0] v);
        status_t                 st;
        beat_t                   b;
        logic signed [VAL_W-1:0] kept [DEPTH];
        int                      n;
        int                      off;
        st = ST_OK;
        case (rq)
            REQ_CREATE, REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (shadow_held == 0) begin
                    shadow_head = 0;
                    shadow_ring[0] = v;
                    shadow_held = 1;
                end else if (rq == REQ_CREATE) begin
                    st = ST_REFUSED;
                end else if (shadow_held >= DEPTH) begin
                    st = ST_FULL;
                end else if (rq == REQ_PUSH_FRONT) begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = v;
                    shadow_held++;
                end else begin
                    shadow_ring[(shadow_head + shadow_held) % DEPTH] = v;
                    shadow_held++;
                end
            end
            REQ_READ_FRONT, REQ_READ_BACK: begin
                if (shadow_held == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int i = 0; i < shadow_held; i++) begin
                        off    = (rq == REQ_READ_FRONT) ? i : shadow_held - 1 - i;
                        b.rd   = shadow_ring[(shadow_head + off) % DEPTH];
                        b.last = (i + 1 == shadow_held);
                        b.st   = ST_OK;
                        b.cnt  = shadow_held[CNT_OUT_W-1:0];
                        expected_beats.push_back(b);
                    end
                    return;
                end
            end
            REQ_CLEAR: begin
                shadow_held = 0;
                shadow_head = 0;
            end
            REQ_DROP_NEG: begin
                n = 0;
                for (int i = 0; i < shadow_held; i++) begin
                    if (!shadow_ring[(shadow_head + i) % DEPTH][VAL_W-1]) begin
                        kept[n] = shadow_ring[(shadow_head + i) % DEPTH];
                        n++;
                    end
                end
                for (int i = 0; i < n; i++) shadow_ring[i] = kept[i];
                shadow_head = 0;
                shadow_held = n;
            end
            default: ;
        endcase
        push_single(st);
    endfunction

    function automatic void add_step(logic [REQ_W-1:0] rq, logic signed [VAL_W-1:0] v,
                                     int rep, bit typed, status_t st, int cnt);
        step_t s;
        s.rq    = rq;
        s.v     = v;
        s.rep   = rep;
        s.typed = typed;
        s.st    = st;
        s.cnt   = cnt[CNT_OUT_W-1:0];
        stim_rows.push_back(s);
    endfunction

    // Offer one beat and hold it until accepted; return with valid still high
    task automatic offer_request(logic [REQ_W-1:0] rq, logic signed [VAL_W-1:0] v,
                                 bit typed, status_t st, logic [CNT_OUT_W-1:0] cnt);
        beat_t b;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_req_type <= rq;
        s_value    <= v;
        do @(posedge aclk); while (!s_ready);
        n_req++;
        if (rq == REQ_PUSH_FRONT || rq == REQ_PUSH_BACK) begin
            if (shadow_held >= DEPTH) n_full++;
        end
        if (rq == REQ_CREATE && shadow_held != 0) n_refused++;
        if ((rq == REQ_READ_FRONT || rq == REQ_READ_BACK) && shadow_held == 0) n_empty_rd++;
        if (rq == REQ_DROP_NEG) n_filter++;
        model_request(rq, v);
        if (typed) begin
            // the table row states this single beat directly
            void'(expected_beats.pop_back());
            b.rd   = '0;
            b.last = 1'b1;
            b.st   = st;
            b.cnt  = cnt;
            expected_beats.push_back(b);
        end
    endtask

    task automatic release_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Bursts of back-to-back beats with random gaps in between
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                release_valid();
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        while (expected_beats.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Weighted choice: mode 0 fills, mode 1 mixes, mode 2 drains
    function automatic logic [REQ_W-1:0] pick_request(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return REQ_UNDEF;
        case (mode)
            0: begin
                if (r < 8)  return REQ_CREATE;
                if (r < 45) return REQ_PUSH_FRONT;
                if (r < 82) return REQ_PUSH_BACK;
                if (r < 88) return REQ_READ_FRONT;
                if (r < 94) return REQ_READ_BACK;
                if (r < 96) return REQ_CLEAR;
                return REQ_DROP_NEG;
            end
            1: begin
                if (r < 10) return REQ_CREATE;
                if (r < 32) return REQ_PUSH_FRONT;
                if (r < 54) return REQ_PUSH_BACK;
                if (r < 68) return REQ_READ_FRONT;
                if (r < 82) return REQ_READ_BACK;
                if (r < 87) return REQ_CLEAR;
                return REQ_DROP_NEG;
            end
            default: begin
                if (r < 10) return REQ_CREATE;
                if (r < 25) return REQ_PUSH_FRONT;
                if (r < 40) return REQ_PUSH_BACK;
                if (r < 55) return REQ_READ_FRONT;
                if (r < 70) return REQ_READ_BACK;
                if (r < 80) return REQ_CLEAR;
                return REQ_DROP_NEG;
            end
        endcase
    endfunction

    // Receiver: ready pattern switches between free flow, coin toss, periodic and long stalls
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(40, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= (rx_tick % 7) >= 3;
            default: begin
                if (rx_hold > 0) begin
                    rx_hold <= rx_hold - 1;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold <= $urandom_range(5, 20);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: read_value %0d last %0b status %0d count %0d",
                       m_read_value, m_last, m_status, m_count);
                err_cnt++;
            end else begin
                beat_t b;
                b = expected_beats.pop_front();
                n_beats++;
                if (m_read_value !== b.rd) begin
                    $error("read_value: expected %0d, got %0d", b.rd, m_read_value);
                    err_cnt++;
                end
                if (m_last !== b.last) begin
                    $error("last: expected %0b, got %0b", b.last, m_last);
                    err_cnt++;
                end
                if (m_status !== b.st) begin
                    $error("status: expected %0d, got %0d", b.st, m_status);
                    err_cnt++;
                end
                if (m_count !== b.cnt) begin
                    $error("count: expected %0d, got %0d", b.cnt, m_count);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int                      n_rand;
        int                      mode;
        int                      mode_left;
        logic [REQ_W-1:0]        rq;
        step_t                   s;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_req_type  = '0;
        s_value     = '0;
        m_ready     = 1'b0;
        shadow_head = 0;
        shadow_held = 0;
        for (int i = 0; i < DEPTH; i++) shadow_ring[i] = '0;

        add_step(REQ_READ_FRONT, 0, 1, 1, ST_EMPTY, 0);
        add_step(REQ_READ_BACK,  0, 1, 1, ST_EMPTY, 0);
        add_step(REQ_DROP_NEG,   0, 1, 1, ST_OK, 0);
        add_step(REQ_CLEAR,      0, 1, 1, ST_OK, 0);
        // push into an empty queue acts as create
        add_step(REQ_PUSH_FRONT, 32'sh8000_0000, 1, 1, ST_OK, 1);
        add_step(REQ_CREATE,     1, 1, 1, ST_REFUSED, 1);
        add_step(REQ_PUSH_BACK,  32'sh7fff_ffff, 1, 0, ST_OK, 0);
        add_step(REQ_PUSH_FRONT, -32'sd1, 1, 0, ST_OK, 0);
        add_step(REQ_PUSH_BACK,  0, 1, 0, ST_OK, 0);
        add_step(REQ_READ_FRONT, 0, 1, 0, ST_OK, 0);
        add_step(REQ_READ_BACK,  0, 1, 0, ST_OK, 0);
        add_step(REQ_DROP_NEG,   0, 1, 0, ST_OK, 0);
        add_step(REQ_READ_FRONT, 0, 1, 0, ST_OK, 0);
        add_step(REQ_CLEAR,      0, 1, 1, ST_OK, 0);
        // a lone negative entry, then the filter empties the queue
        add_step(REQ_PUSH_BACK,  -32'sd7, 1, 1, ST_OK, 1);
        add_step(REQ_DROP_NEG,   0, 1, 1, ST_OK, 0);
        add_step(REQ_CREATE,     32'sh0000_1234, 1, 1, ST_OK, 1);
        add_step(REQ_PUSH_FRONT, 32'sh8000_0010, 7, 0, ST_OK, 0);
        add_step(REQ_PUSH_BACK,  100, 8, 0, ST_OK, 0);
        add_step(REQ_PUSH_BACK,  5, 1, 1, ST_FULL, DEPTH);
        add_step(REQ_PUSH_FRONT, 6, 1, 1, ST_FULL, DEPTH);
        add_step(REQ_UNDEF,      -32'sd1, 1, 1, ST_OK, DEPTH);
        add_step(REQ_READ_BACK,  0, 1, 0, ST_OK, 0);
        add_step(REQ_DROP_NEG,   0, 1, 0, ST_OK, 0);
        add_step(REQ_READ_FRONT, 0, 1, 0, ST_OK, 0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            s = stim_rows[i];
            for (int k = 0; k < s.rep; k++) begin
                offer_request(s.rq, s.v + k, s.typed, s.st, s.cnt);
                pace();
            end
        end

        n_rand    = 0;
        mode      = 0;
        mode_left = 0;
        while (n_rand < RAND_ITEMS) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(15, 40);
            end
            mode_left--;
            rq = pick_request(mode);
            offer_request(rq, pick_value(), 0, ST_OK, 0);
            if (rq != REQ_UNDEF) n_rand++;
            if (n_rand == RAND_ITEMS / 2 && rq != REQ_UNDEF) begin
                // hold off until every outstanding beat has come back
                release_valid();
                drain_results();
            end else begin
                pace();
            end
        end

        release_valid();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb: %0d requests, %0d result beats checked, %0d errors", n_req, n_beats,
                 err_cnt);
        $display("tb: %0d pushes into a full queue, %0d refused creates, %0d empty readouts,",
                 n_full, n_refused, n_empty_rd);
        $display("tb: %0d filters", n_filter);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
